// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Operation codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // operation codes of one input transfer
    typedef enum logic [2:0] {
        FUNC_PUT_CHAR   = 3'd0,
        FUNC_BACKSPACE  = 3'd1,
        FUNC_CLEAR      = 3'd2,
        FUNC_SET_ATTR   = 3'd3,
        FUNC_RESET_ATTR = 3'd4,
        FUNC_READ_CELL  = 3'd5
    } t_func;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CELL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'b1;

    localparam logic [15:0] BLANK_CELL_RESET   = 16'h0220;
    localparam logic [7:0]  DEFAULT_ATTR_RESET = 8'h02;
    localparam logic [7:0]  NEWLINE_CODE       = 8'h0A;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_SCROLL,
        ST_SC_FILL,
        ST_CLEAR,
        ST_BS_READ,
        ST_BS_CHECK,
        ST_BS_ERASE,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic home;
        logic idx_clear;
        logic fill_step;
        logic fill_reset;
        logic copy_step;
        logic advance_row;
        logic put_write;
        logic bs_step;
        logic bs_erase;
        logic rd_issue;
        logic rd_capture;
        logic attr_set;
        logic attr_default;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  is_newline;
        logic  col_at_wrap;
        logic  row_at_bottom;
        logic  at_origin;
        logic  fill_last;
        logic  copy_last;
        logic  cell_blank;
    } t_dp_stat;

endpackage

// ===== sv/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl: console controller
// Sequences each operation and the memory sweeps over the screen store.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tcw_pkg::t_dp_stat i_stat,
    output tcw_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_stat.fill_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (i_stat.func)
                    FUNC_PUT_CHAR: begin
                        if (i_stat.is_newline || i_stat.col_at_wrap) begin
                            if (i_stat.row_at_bottom) n_state = ST_SCROLL;
                            else if (i_stat.is_newline) n_state = ST_DONE;
                            else n_state = ST_PUT;
                        end else begin
                            n_state = ST_PUT;
                        end
                    end
                    FUNC_BACKSPACE: begin
                        n_state = i_stat.at_origin ? ST_DONE : ST_BS_READ;
                    end
                    FUNC_CLEAR:     n_state = ST_CLEAR;
                    FUNC_READ_CELL: n_state = ST_RD_WAIT;
                    default:        n_state = ST_DONE;
                endcase
            end
            ST_PUT:     n_state = ST_DONE;
            ST_SCROLL: begin
                if (i_stat.copy_last) n_state = ST_SC_FILL;
            end
            ST_SC_FILL: begin
                if (i_stat.fill_last) n_state = i_stat.is_newline ? ST_DONE : ST_PUT;
            end
            ST_CLEAR: begin
                if (i_stat.fill_last) n_state = ST_DONE;
            end
            ST_BS_READ: n_state = ST_BS_CHECK;
            ST_BS_CHECK: begin
                if (!i_stat.cell_blank || i_stat.at_origin) n_state = ST_BS_ERASE;
                else n_state = ST_BS_READ;
            end
            ST_BS_ERASE: n_state = ST_DONE;
            ST_RD_WAIT:  n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        case (r_state)
            ST_INIT: begin
                o_cmd.fill_step  = 1'b1;
                o_cmd.fill_reset = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.latch = i_start;
            end
            ST_DECODE: begin
                case (i_stat.func)
                    FUNC_PUT_CHAR: begin
                        if (i_stat.is_newline || i_stat.col_at_wrap) begin
                            o_cmd.advance_row = 1'b1;
                            o_cmd.idx_clear   = i_stat.row_at_bottom;
                        end
                    end
                    FUNC_BACKSPACE: o_cmd.bs_step = !i_stat.at_origin;
                    FUNC_CLEAR: begin
                        o_cmd.home      = 1'b1;
                        o_cmd.idx_clear = 1'b1;
                    end
                    FUNC_SET_ATTR:   o_cmd.attr_set     = 1'b1;
                    FUNC_RESET_ATTR: o_cmd.attr_default = 1'b1;
                    FUNC_READ_CELL:  o_cmd.rd_issue     = 1'b1;
                    default: ;
                endcase
            end
            ST_PUT:      o_cmd.put_write  = 1'b1;
            ST_SCROLL:   o_cmd.copy_step  = 1'b1;
            ST_SC_FILL:  o_cmd.fill_step  = 1'b1;
            ST_CLEAR:    o_cmd.fill_step  = 1'b1;
            ST_BS_CHECK: o_cmd.bs_step    = i_stat.cell_blank && !i_stat.at_origin;
            ST_BS_ERASE: o_cmd.bs_erase   = 1'b1;
            ST_RD_WAIT:  o_cmd.rd_capture = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== sv/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp: console datapath
// Cursor, attribute and config registers, sweep counter and screen store.
// ----------------------------------------------------------------------------
module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcw_pkg::t_dp_cmd                 i_cmd,
    output tcw_pkg::t_dp_stat                o_stat,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                      i_cfg_wdata,
    input  logic [2:0]                       i_func,
    input  logic [7:0]                       i_char_code,
    input  logic [7:0]                       i_new_attribute,
    input  logic [4:0]                       i_read_row,
    input  logic [6:0]                       i_read_column,
    output logic [15:0]                      o_cell_value,
    output logic [4:0]                       o_cursor_row,
    output logic [6:0]                       o_cursor_column
);
    import tcw_pkg::*;

    localparam int N  = ROWS * COLUMNS;
    localparam int AW = $clog2(N);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam logic [AW-1:0] COPY_END = AW'(N - COLUMNS);
    localparam logic [AW-1:0] LAST_IDX = AW'(N - 1);

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [7:0]    r_attr;
    logic [15:0]   r_blank;
    logic [7:0]    r_def_attr;
    logic [AW-1:0] r_idx;
    t_func         r_func;
    logic [7:0]    r_char;
    logic [7:0]    r_new_attr;
    logic [4:0]    r_rrow;
    logic [6:0]    r_rcol;
    logic [15:0]   r_value;

    logic [AW-1:0] w_cur_addr;
    logic [AW-1:0] w_cell_addr;
    logic          w_in_range;
    logic          w_copy_last;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rdata;

    assign w_cur_addr  = AW'(32'(r_row) * COLUMNS + 32'(r_col));
    assign w_in_range  = (32'(r_rrow) < ROWS) && (32'(r_rcol) < COLUMNS);
    assign w_cell_addr = w_in_range ? AW'(32'(r_rrow) * COLUMNS + 32'(r_rcol)) : '0;
    assign w_copy_last = (r_idx == COPY_END);

    // read address: scroll source row, cell lookup, or the cursor cell
    always_comb begin
        if (i_cmd.copy_step) begin
            w_raddr = w_copy_last ? r_idx : r_idx + AW'(COLUMNS);
        end else if (i_cmd.rd_issue) begin
            w_raddr = w_cell_addr;
        end else begin
            w_raddr = w_cur_addr;
        end
    end

    // write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_cur_addr;
        w_wdata = r_blank;
        if (i_cmd.fill_step) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = i_cmd.fill_reset ? BLANK_CELL_RESET : r_blank;
        end else if (i_cmd.copy_step) begin
            // copy lags the read: each step writes the cell read on the step before
            w_we    = (r_idx != '0);
            w_waddr = r_idx - AW'(1);
            w_wdata = w_rdata;
        end else if (i_cmd.put_write) begin
            w_we    = 1'b1;
            w_wdata = {r_attr, r_char};
        end else if (i_cmd.bs_erase) begin
            w_we    = 1'b1;
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (N)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_attr     <= DEFAULT_ATTR_RESET;
            r_blank    <= BLANK_CELL_RESET;
            r_def_attr <= DEFAULT_ATTR_RESET;
            r_idx      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLANK_CELL:   r_blank    <= i_cfg_wdata;
                    CFG_DEFAULT_ATTR: r_def_attr <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.fill_step) begin
                r_idx <= r_idx + AW'(1);
            end else if (i_cmd.copy_step && !w_copy_last) begin
                r_idx <= r_idx + AW'(1);
            end

            if (i_cmd.home) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.advance_row) begin
                r_col <= '0;
                if (32'(r_row) != ROWS - 1) r_row <= r_row + RW'(1);
            end else if (i_cmd.put_write) begin
                r_col <= r_col + CW'(1);
            end else if (i_cmd.bs_step) begin
                if (r_col == '0) begin
                    r_row <= r_row - RW'(1);
                    r_col <= CW'(COLUMNS - 1);
                end else begin
                    r_col <= r_col - CW'(1);
                end
            end

            if (i_cmd.attr_set) begin
                r_attr <= r_new_attr;
            end else if (i_cmd.attr_default) begin
                r_attr <= r_def_attr;
            end
        end
    end

    // operands and result value
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func     <= t_func'(i_func);
            r_char     <= i_char_code;
            r_new_attr <= i_new_attribute;
            r_rrow     <= i_read_row;
            r_rcol     <= i_read_column;
            r_value    <= '0;
        end else if (i_cmd.rd_capture) begin
            r_value <= w_in_range ? w_rdata : '0;
        end
    end

    assign o_stat.func          = r_func;
    assign o_stat.is_newline    = (r_char == NEWLINE_CODE);
    assign o_stat.col_at_wrap   = (32'(r_col) >= COLUMNS);
    assign o_stat.row_at_bottom = (32'(r_row) == ROWS - 1);
    assign o_stat.at_origin     = (r_row == '0) && (r_col == '0);
    assign o_stat.fill_last     = (r_idx == LAST_IDX);
    assign o_stat.copy_last     = w_copy_last;
    assign o_stat.cell_blank    = (w_rdata == r_blank);

    assign o_cell_value    = r_value;
    assign o_cursor_row    = 5'(r_row);
    assign o_cursor_column = 7'(r_col);

endmodule

// ===== sv/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top: text-mode console engine
// Screen of character cells with cursor, attribute and six operations.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its single
// result shows on the result ports for one cycle with o_done high, and the
// receiver cannot stall it. Item time is set by the controller walking the
// screen store, which has one write and one read port: set and reset
// attribute and a plain newline pass through decode and done only, put
// char and read cell add a write or a read state, clear screen blanks every
// cell, a newline or wrap on the last row adds a scroll (one cell copied
// or blanked per cycle), and backspace reads and checks each cell walked
// back, then erases one. After reset a clearing pass over every cell holds
// busy high; config writes are taken at any time and apply at once.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
    parameter int COLUMNS = 80,   // 8 to 127
    parameter int ROWS    = 25    // 2 to 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command transfer
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_func,
    input  logic [7:0]                    i_char_code,
    input  logic [7:0]                    i_new_attribute,
    input  logic [4:0]                    i_read_row,
    input  logic [6:0]                    i_read_column,
    // result transfer, one cycle wide
    output logic                          o_done,
    output logic [15:0]                   o_cell_value,
    output logic [4:0]                    o_cursor_row,
    output logic [6:0]                    o_cursor_column,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_wdata
);
    import tcw_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing of operations and sweeps
    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // registers, address math and the screen store
    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_func          (i_func),
        .i_char_code     (i_char_code),
        .i_new_attribute (i_new_attribute),
        .i_read_row      (i_read_row),
        .i_read_column   (i_read_column),
        .o_cell_value    (o_cell_value),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column)
    );

endmodule

// ===== tb/text_console_writer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top_test: self-checking bench for the console engine
// Drives a short table of directed commands, then random console traffic
// (text lines, wraps, newlines that scroll, backspace runs, attribute
// changes, cell reads, clears), and checks every result transfer against
// an in-bench model of the screen, cursor and attribute. Four config phases.
// ----------------------------------------------------------------------------
module text_console_writer_top_test;
    import tcw_pkg::*;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int PHASE_ITEMS  = 260;

    // codes the block leaves undefined: no state change, zero cell value
    localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  row;
        logic [6:0]  col;
    } t_console_report;

    // one line of the directed table; reps repeats the same command
    typedef struct packed {
        logic [2:0]      func;
        logic [7:0]      ch;
        logic [7:0]      attr;
        logic [4:0]      rd_row;
        logic [6:0]      rd_col;
        logic [7:0]      reps;
        logic            typed;
        t_console_report want;
    } t_cmd_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [7:0]  i_char_code;
    logic [7:0]  i_new_attribute;
    logic [4:0]  i_read_row;
    logic [6:0]  i_read_column;
    logic        o_done;
    logic [15:0] o_cell_value;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_column;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_wdata;

    // screen model: cells, cursor, attribute and the two config registers
    logic [15:0] screen_model [0:SCREEN_CELLS-1];
    int          cur_row;
    int          cur_col;
    logic [7:0]  cur_attr;
    logic [7:0]  dflt_attr;
    logic [15:0] blank_reg;

    t_console_report awaited_reports [$];
    int              mismatch_count = 0;
    int              items_sent     = 0;
    int              burst_left     = 0;

    text_console_writer_top #(
        .COLUMNS(SCREEN_COLS),
        .ROWS   (SCREEN_ROWS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_char_code    (i_char_code),
        .i_new_attribute(i_new_attribute),
        .i_read_row     (i_read_row),
        .i_read_column  (i_read_column),
        .o_done         (o_done),
        .o_cell_value   (o_cell_value),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_column(o_cursor_column),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // screen model
    // ------------------------------------------------------------------------
    task automatic blank_fill(input int from, input int upto);
        for (int i = from; i < upto; i++) screen_model[i] = blank_reg;
    endtask

    // carriage return plus line feed, scrolling up one row past the bottom
    task automatic next_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= SCREEN_ROWS) begin
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                screen_model[i] = screen_model[i + SCREEN_COLS];
            blank_fill(SCREEN_CELLS - SCREEN_COLS, SCREEN_CELLS);
            cur_row = SCREEN_ROWS - 1;
        end
    endtask

    task automatic predict_console_report(input logic [2:0] f, input logic [7:0] ch,
                                          input logic [7:0] attr, input logic [4:0] rr,
                                          input logic [6:0] rc,
                                          output t_console_report rep);
        int          idx;
        logic [15:0] value;
        value = '0;
        case (f)
            FUNC_PUT_CHAR: begin
                if (ch == NEWLINE_CODE) begin
                    next_line();
                end else begin
                    // lazy wrap: the column may sit at COLUMNS until the next char
                    if (cur_col >= SCREEN_COLS) next_line();
                    screen_model[cur_row * SCREEN_COLS + cur_col] = {cur_attr, ch};
                    cur_col++;
                end
            end
            FUNC_BACKSPACE: begin
                if (cur_row != 0 || cur_col != 0) begin
                    // walk back over blanks, never past the origin
                    do begin
                        if (cur_col == 0) begin
                            cur_row--;
                            cur_col = SCREEN_COLS - 1;
                        end else begin
                            cur_col--;
                        end
                        idx = cur_row * SCREEN_COLS + cur_col;
                    end while (screen_model[idx] == blank_reg && (cur_row != 0 || cur_col != 0));
                    screen_model[idx] = blank_reg;
                end
            end
            FUNC_CLEAR: begin
                blank_fill(0, SCREEN_CELLS);
                cur_row = 0;
                cur_col = 0;
            end
            FUNC_SET_ATTR:   cur_attr = attr;
            FUNC_RESET_ATTR: cur_attr = dflt_attr;
            FUNC_READ_CELL: begin
                if (rr < SCREEN_ROWS && rc < SCREEN_COLS)
                    value = screen_model[rr * SCREEN_COLS + rc];
            end
            default: ;
        endcase
        rep.cell_data = value;
        rep.row       = cur_row[4:0];
        rep.col       = cur_col[6:0];
    endtask

    // ------------------------------------------------------------------------
    // command side: bursts of back-to-back transfers with random gaps
    // ------------------------------------------------------------------------
    // called at a falling edge, returns at a falling edge with start still up
    task automatic issue_command(input logic [2:0] f, input logic [7:0] ch,
                                 input logic [7:0] attr, input logic [4:0] rr,
                                 input logic [6:0] rc, input logic typed,
                                 input t_console_report typed_want);
        t_console_report predicted;
        int              gap;
        int              pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)      gap = 0;
            else if (pick < 9) gap = $urandom_range(1, 12);
            else               gap = $urandom_range(20, 60);
            if (gap > 0) begin
                start = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_func          = f;
        i_char_code     = ch;
        i_new_attribute = attr;
        i_read_row      = rr;
        i_read_column   = rc;
        start           = 1'b1;
        // transfer happens at the first rising edge that sees busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_console_report(f, ch, attr, rr, rc, predicted);
        awaited_reports.push_back(typed ? typed_want : predicted);
        items_sent++;
        @(negedge i_clk);
    endtask

    // config registers only move with nothing in flight
    task automatic drain_and_idle();
        start      = 1'b0;
        burst_left = 0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        while (busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        // neither write repaints the screen or touches the current attribute
        if (idx == CFG_BLANK_CELL) blank_reg = data;
        else                       dflt_attr = data[7:0];
    endtask

    function automatic logic [7:0] random_glyph();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_cmd_row table_row(input logic [2:0] f, input logic [7:0] ch,
                                           input logic [7:0] attr, input logic [4:0] rr,
                                           input logic [6:0] rc, input logic [7:0] reps,
                                           input logic typed, input logic [15:0] want_cell,
                                           input logic [4:0] crow, input logic [6:0] ccol);
        t_cmd_row r;
        r.func   = f;
        r.ch     = ch;
        r.attr   = attr;
        r.rd_row = rr;
        r.rd_col = rc;
        r.reps   = reps;
        r.typed  = typed;
        r.want   = {want_cell, crow, ccol};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: one-cycle strobe, checked against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_console_report got;
        t_console_report want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            got = {o_cell_value, o_cursor_row, o_cursor_column};
            if (awaited_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: cell %h row %0d col %0d",
                             got.cell_data, got.row, got.col);
            end else begin
                want = awaited_reports.pop_front();
                if (got.cell_data !== want.cell_data || got.row !== want.row ||
                    got.col !== want.col) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: cell %h/%h row %0d/%0d col %0d/%0d (exp/act)",
                                 want.cell_data, got.cell_data, want.row, got.row,
                                 want.col, got.col);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_cmd_row          directed_table [$];
        t_cmd_row          r;
        t_console_report   none;
        int                kind;
        int                len;
        int                guard;
        int                phase_goal;
        logic [15:0]       cfg_blank;
        logic [7:0]        cfg_attr;
        logic [7:0]        junk;
        logic [4:0]        rr;
        logic [6:0]        rc;

        none            = '0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = FUNC_PUT_CHAR;
        i_char_code     = '0;
        i_new_attribute = '0;
        i_read_row      = '0;
        i_read_column   = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_BLANK_CELL;
        i_cfg_wdata     = '0;

        // model starts where the block's clearing pass leaves it
        blank_reg = BLANK_CELL_RESET;
        dflt_attr = DEFAULT_ATTR_RESET;
        cur_attr  = DEFAULT_ATTR_RESET;
        cur_row   = 0;
        cur_col   = 0;
        blank_fill(0, SCREEN_CELLS);

        // directed table: fixed results only where obvious, else the model decides
        // fresh screen reads blank at the corners, out-of-range reads answer zero
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 0, 0, 1, 1, 16'h0220, 0, 0));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 24, 79, 1, 1, 16'h0220, 0, 0));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 25, 0, 1, 1, 16'h0000, 0, 0));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 0, 80, 1, 1, 16'h0000, 0, 0));
        directed_table.push_back(table_row(FUNC_READ_CELL, 8'hFF, 8'hFF, 31, 127, 1, 1,
                                           16'h0000, 0, 0));
        // backspace at the origin does nothing
        directed_table.push_back(table_row(FUNC_BACKSPACE, 0, 0, 0, 0, 1, 1, 16'h0000, 0, 0));
        // unused codes, even with a newline char and the other fields all ones, leave the state alone
        directed_table.push_back(table_row(FUNC_UNUSED_6, 8'hFF, 8'hFF, 31, 127, 1, 1,
                                           16'h0000, 0, 0));
        directed_table.push_back(table_row(FUNC_UNUSED_7, 8'h0A, 8'hFF, 31, 127, 1, 1,
                                           16'h0000, 0, 0));
        // char extremes, then read them back with the default attribute
        directed_table.push_back(table_row(FUNC_PUT_CHAR, 8'hFF, 0, 0, 0, 1, 1, 16'h0000, 0, 1));
        directed_table.push_back(table_row(FUNC_PUT_CHAR, 8'h00, 0, 0, 0, 1, 1, 16'h0000, 0, 2));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 0, 0, 1, 1, 16'h02FF, 0, 2));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 0, 1, 1, 1, 16'h0200, 0, 2));
        directed_table.push_back(table_row(FUNC_SET_ATTR, 0, 8'hFF, 0, 0, 1, 1, 16'h0000, 0, 2));
        directed_table.push_back(table_row(FUNC_PUT_CHAR, 8'h41, 0, 0, 0, 1, 1, 16'h0000, 0, 3));
        directed_table.push_back(table_row(FUNC_RESET_ATTR, 0, 0, 0, 0, 1, 1, 16'h0000, 0, 3));
        // space on the default attribute equals the blank cell
        directed_table.push_back(table_row(FUNC_PUT_CHAR, 8'h20, 0, 0, 0, 1, 1, 16'h0000, 0, 4));
        directed_table.push_back(table_row(FUNC_PUT_CHAR, NEWLINE_CODE, 0, 0, 0, 1, 1,
                                           16'h0000, 1, 0));
        // backspace from column 0 walks up a row and over the blank space
        directed_table.push_back(table_row(FUNC_BACKSPACE, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 0, 2, 1, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_SET_ATTR, 0, 8'h00, 0, 0, 1, 0, 0, 0, 0));
        // newlines past the bottom scroll, then a full row wraps on the last row
        directed_table.push_back(table_row(FUNC_PUT_CHAR, NEWLINE_CODE, 0, 0, 0, 30, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_PUT_CHAR, 8'h7E, 0, 0, 0, 82, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 24, 0, 1, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_READ_CELL, 0, 0, 23, 79, 1, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_CLEAR, 0, 0, 0, 0, 1, 1, 16'h0000, 0, 0));
        // backspace run that ends at the origin
        directed_table.push_back(table_row(FUNC_PUT_CHAR, 8'h78, 0, 0, 0, 3, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_BACKSPACE, 0, 0, 0, 0, 5, 0, 0, 0, 0));
        // walk over whole blank rows down to the origin
        directed_table.push_back(table_row(FUNC_PUT_CHAR, NEWLINE_CODE, 0, 0, 0, 3, 0, 0, 0, 0));
        directed_table.push_back(table_row(FUNC_BACKSPACE, 0, 0, 0, 0, 1, 0, 0, 0, 0));

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_table[i]) begin
            r = directed_table[i];
            repeat (r.reps)
                issue_command(r.func, r.ch, r.attr, r.rd_row, r.rd_col, r.typed, r.want);
        end

        // random traffic in four config phases, extremes first
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin cfg_blank = 16'h0000; cfg_attr = 8'h00; end
                1: begin cfg_blank = 16'hFFFF; cfg_attr = 8'hFF; end
                2: begin
                    cfg_attr  = 8'($urandom);
                    cfg_blank = {8'($urandom), 8'h20};
                end
                default: begin cfg_blank = BLANK_CELL_RESET; cfg_attr = DEFAULT_ATTR_RESET; end
            endcase
            drain_and_idle();
            junk = 8'($urandom);
            write_register(CFG_BLANK_CELL, cfg_blank);
            write_register(CFG_DEFAULT_ATTR, {junk, cfg_attr});

            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                kind = $urandom_range(0, 99);
                if (kind < 45) begin
                    // a line of text, sometimes long enough to wrap
                    if ($urandom_range(0, 99) < 15) len = $urandom_range(70, 100);
                    else                            len = $urandom_range(0, 30);
                    repeat (len)
                        issue_command(FUNC_PUT_CHAR, random_glyph(), 8'($urandom),
                                      5'($urandom), 7'($urandom), 1'b0, none);
                    if ($urandom_range(0, 99) < 70)
                        issue_command(FUNC_PUT_CHAR, NEWLINE_CODE, 8'($urandom),
                                      5'($urandom), 7'($urandom), 1'b0, none);
                end else if (kind < 60) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                      : $urandom_range(1, 6);
                    repeat (len)
                        issue_command(FUNC_BACKSPACE, 8'($urandom), 8'($urandom),
                                      5'($urandom), 7'($urandom), 1'b0, none);
                end else if (kind < 70) begin
                    issue_command(FUNC_SET_ATTR, 8'($urandom), 8'($urandom),
                                  5'($urandom), 7'($urandom), 1'b0, none);
                end else if (kind < 75) begin
                    issue_command(FUNC_RESET_ATTR, 8'($urandom), 8'($urandom),
                                  5'($urandom), 7'($urandom), 1'b0, none);
                end else if (kind < 90) begin
                    repeat ($urandom_range(1, 4)) begin
                        len = $urandom_range(0, 9);
                        if (len < 2) begin
                            // anywhere the fields reach, off-screen included
                            rr = 5'($urandom);
                            rc = 7'($urandom);
                        end else if (len < 5) begin
                            // around the cursor
                            rr = 5'(cur_row);
                            rc = 7'((cur_col > 0) ? cur_col - 1 : 0);
                        end else begin
                            rr = 5'($urandom_range(0, SCREEN_ROWS - 1));
                            rc = 7'($urandom_range(0, SCREEN_COLS - 1));
                        end
                        issue_command(FUNC_READ_CELL, 8'($urandom), 8'($urandom),
                                      rr, rc, 1'b0, none);
                    end
                end else if (kind < 94) begin
                    // newline runs push the cursor to the bottom and scroll
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 26)
                                                      : $urandom_range(1, 6);
                    repeat (len)
                        issue_command(FUNC_PUT_CHAR, NEWLINE_CODE, 8'($urandom),
                                      5'($urandom), 7'($urandom), 1'b0, none);
                end else if (kind < 96) begin
                    issue_command(FUNC_CLEAR, 8'($urandom), 8'($urandom),
                                  5'($urandom), 7'($urandom), 1'b0, none);
                end else begin
                    issue_command(($urandom_range(0, 1) == 0) ? FUNC_UNUSED_6 : FUNC_UNUSED_7,
                                  8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom),
                                  1'b0, none);
                end
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        // longest item is a backspace walk over the whole screen
        guard = 0;
        while (awaited_reports.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (32) @(posedge i_clk);
        mismatch_count += awaited_reports.size();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
